// ===== rtl/world_to_screen_projection_assert.svh =====
// assertion macros shared by the checker of the projection block
// depends on nothing; take in by `include inside a module body
`ifndef WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH

// same-cycle implication, quiet during reset
`define WSP_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("wsp check failed");

// next-cycle implication, quiet during reset
`define WSP_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("wsp check failed");

// next-cycle implication that also holds across reset
`define WSP_ASSERT_ALWAYS_NEXT(label, clk, cond, prop) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("wsp check failed");

`endif

// ===== rtl/wsp_pkg.sv =====
// types, codes and helper functions of the world to screen projection block
// depends on nothing; used by the top level, the divider and the checker
package wsp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COEF_COUNT    = 28;
  localparam int PROJ_BASE     = 12;
  localparam int DIV_BITS      = 4;   // quotient bits resolved per divider stage

  localparam logic [15:0] VP_WIDTH_RST  = 16'd640;
  localparam logic [15:0] VP_HEIGHT_RST = 16'd480;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_PROJECT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_PROJECTED = 2'd0,
    ST_BEHIND    = 2'd1,
    ST_W_ZERO    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_VP_X      = 2'd0,
    CFG_VP_Y      = 2'd1,
    CFG_VP_WIDTH  = 2'd2,
    CFG_VP_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              op;
    logic [4:0]        coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } vertex_t;

  typedef struct packed {
    logic [1:0]        status;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] clip_z;
  } result_t;

  // sideband that rides along the divider
  typedef struct packed {
    status_t           status;
    logic signed [31:0] clip_z;
    logic              neg_x;
    logic              neg_y;
    logic              max_x;
    logic              max_y;
  } side_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = S32_MAX;
    else if (v < -66'sd2147483648) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // one matrix row: floor of each scaled product plus the bias, saturated
  function automatic logic signed [31:0] row_sum(input logic signed [63:0] p0,
                                                 input logic signed [63:0] p1,
                                                 input logic signed [63:0] p2,
                                                 input logic signed [31:0] bias,
                                                 input int frac);
    logic signed [65:0] acc;
    acc = ($signed({{2{p0[63]}}, p0}) >>> frac) + ($signed({{2{p1[63]}}, p1}) >>> frac)
        + ($signed({{2{p2[63]}}, p2}) >>> frac) + 66'(bias);
    return sat32(acc);
  endfunction

  // magnitude of a signed 32-bit value
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(0 - v) : v;
  endfunction

endpackage

// ===== rtl/world_to_screen_projection.sv =====
// top level of the world to screen projection block
// depends on wsp_pkg and wsp_divider
//
// One item per clock, back to back, when the output does not stall. A load item
// writes one matrix coefficient (none for an index of COEF_COUNT or more) and
// gives no result; a project item gives one result. The pipeline holds the view
// and projection multiplies (two stages each) and the restoring divider, which
// resolves four quotient bits per stage. Results come out in order; a full
// output register stalls the pipeline only as far back as there are no empty
// stages. Coefficient loads take effect in order with projections in flight.
// The viewport registers are meant to be written while no item is in flight.
module world_to_screen_projection #(
  parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             vertex_valid,
  output logic             vertex_ready,
  input  wsp_pkg::vertex_t vertex,
  output logic             result_valid,
  input  logic             result_ready,
  output wsp_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import wsp_pkg::*;

  localparam int QW = ((32 + FRAC_BITS + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

  // viewport registers
  logic [15:0] vp_x, vp_y, vp_w, vp_h;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vp_x <= '0;
      vp_y <= '0;
      vp_w <= VP_WIDTH_RST;
      vp_h <= VP_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_VP_X:      vp_x <= cfg_data;
        CFG_VP_Y:      vp_y <= cfg_data;
        CFG_VP_WIDTH:  vp_w <= cfg_data;
        CFG_VP_HEIGHT: vp_h <= cfg_data;
        default:       vp_x <= vp_x;
      endcase
    end
  end

  // pipeline registers
  logic a_v, b_v, c_v, d_v, e_v, f_v, g_v, h_v;
  logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy, f_rdy, g_rdy, h_rdy, div_rdy;

  vertex_t a;
  logic signed [63:0] b_p [9];
  logic signed [31:0] b_bias [3];
  logic              b_op;
  logic [4:0]        b_idx;
  logic signed [31:0] b_val;
  logic signed [31:0] c_ex, c_ey, c_ez;
  logic              c_op;
  logic [4:0]        c_idx;
  logic signed [31:0] c_val;
  logic signed [63:0] d_p [12];
  logic signed [31:0] d_bias [4];
  logic              d_behind;
  logic signed [31:0] e_cx, e_cy, e_cz, e_cw;
  logic              e_behind;
  side_t             f_side, g_side, div_side_in, div_side_out;
  logic signed [33:0] f_nx, f_ny;
  logic signed [50:0] g_px, g_py;
  logic              div_v;
  logic [QW-1:0]     quo_x, quo_y;

  // coefficient store, entries read at fixed places
  logic signed [31:0] coef [COEF_COUNT];

  // stall chain from the output back to the input
  assign h_rdy = !h_v || result_ready;
  assign g_rdy = !g_v || h_rdy;
  assign f_rdy = !f_v || g_rdy;
  assign e_rdy = !e_v || div_rdy;
  assign d_rdy = !d_v || e_rdy;
  assign c_rdy = !c_v || d_rdy;
  assign b_rdy = !b_v || c_rdy;
  assign a_rdy = !a_v || b_rdy;
  assign vertex_ready = a_rdy;

  // view coefficients are written as a load passes stage a, projection ones at c
  always_ff @(posedge clk) begin
    if (a_v && a.op == OP_LOAD && a.coef_index < 5'(PROJ_BASE))
      coef[a.coef_index] <= a.coef_value;
    if (c_v && c_op == OP_LOAD && c_idx >= 5'(PROJ_BASE) && c_idx < 5'(COEF_COUNT))
      coef[c_idx] <= c_val;
  end

  // valid bits; load items leave after stage c
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0; b_v <= 1'b0; c_v <= 1'b0; d_v <= 1'b0;
      e_v <= 1'b0; f_v <= 1'b0; g_v <= 1'b0; h_v <= 1'b0;
    end else begin
      if (a_rdy) a_v <= vertex_valid;
      if (b_rdy) b_v <= a_v;
      if (c_rdy) c_v <= b_v;
      if (d_rdy) d_v <= c_v && c_op == OP_PROJECT;
      if (e_rdy) e_v <= d_v;
      if (f_rdy) f_v <= div_v;
      if (g_rdy) g_v <= f_v;
      if (h_rdy) h_v <= g_v;
    end
  end

  // stage a: input register
  always_ff @(posedge clk) begin
    if (a_rdy) a <= vertex;
  end

  // stage b: view matrix products
  always_ff @(posedge clk) begin
    if (b_rdy) begin
      for (int r = 0; r < 3; r++) begin
        b_p[3*r]   <= coef[4*r]     * a.world_x;
        b_p[3*r+1] <= coef[4*r + 1] * a.world_y;
        b_p[3*r+2] <= coef[4*r + 2] * a.world_z;
        b_bias[r]  <= coef[4*r + 3];
      end
      b_op  <= a.op;
      b_idx <= a.coef_index;
      b_val <= a.coef_value;
    end
  end

  // stage c: eye coordinates
  always_ff @(posedge clk) begin
    if (c_rdy) begin
      c_ex  <= row_sum(b_p[0], b_p[1], b_p[2], b_bias[0], FRAC_BITS);
      c_ey  <= row_sum(b_p[3], b_p[4], b_p[5], b_bias[1], FRAC_BITS);
      c_ez  <= row_sum(b_p[6], b_p[7], b_p[8], b_bias[2], FRAC_BITS);
      c_op  <= b_op;
      c_idx <= b_idx;
      c_val <= b_val;
    end
  end

  // stage d: projection matrix products
  always_ff @(posedge clk) begin
    if (d_rdy) begin
      for (int r = 0; r < 4; r++) begin
        d_p[3*r]   <= coef[PROJ_BASE + 4*r]     * c_ex;
        d_p[3*r+1] <= coef[PROJ_BASE + 4*r + 1] * c_ey;
        d_p[3*r+2] <= coef[PROJ_BASE + 4*r + 2] * c_ez;
        d_bias[r]  <= coef[PROJ_BASE + 4*r + 3];
      end
      d_behind <= c_ez > 32'sd0;
    end
  end

  // stage e: clip coordinates
  always_ff @(posedge clk) begin
    if (e_rdy) begin
      e_cx     <= row_sum(d_p[0], d_p[1], d_p[2], d_bias[0], FRAC_BITS);
      e_cy     <= row_sum(d_p[3], d_p[4], d_p[5], d_bias[1], FRAC_BITS);
      e_cz     <= row_sum(d_p[6], d_p[7], d_p[8], d_bias[2], FRAC_BITS);
      e_cw     <= row_sum(d_p[9], d_p[10], d_p[11], d_bias[3], FRAC_BITS);
      e_behind <= d_behind;
    end
  end

  // status and sideband for the divide
  always_comb begin
    div_side_in.status = e_behind ? ST_BEHIND : (e_cw == '0 ? ST_W_ZERO : ST_PROJECTED);
    div_side_in.clip_z = e_behind ? '0 : e_cz;
    div_side_in.neg_x  = e_cx[31] ^ e_cw[31];
    div_side_in.neg_y  = e_cy[31] ^ e_cw[31];
    div_side_in.max_x  = !e_cx[31];
    div_side_in.max_y  = !e_cy[31];
  end

  wsp_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (e_v),
    .in_ready (div_rdy),
    .num_x    (mag32(e_cx)),
    .num_y    (mag32(e_cy)),
    .den      (mag32(e_cw)),
    .in_side  (div_side_in),
    .out_valid(div_v),
    .out_ready(f_rdy),
    .quo_x    (quo_x),
    .quo_y    (quo_y),
    .out_side (div_side_out)
  );

  // signed, saturated normalized coordinate from a quotient magnitude
  function automatic logic signed [31:0] to_ndc(input logic [QW-1:0] q, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if ((|q[QW-1:32]) || (q[31] && (|q[30:0]))) r = S32_MIN;
      else r = 32'(33'd0 - q[32:0]);
    end else begin
      if (|q[QW-1:31]) r = S32_MAX;
      else r = q[31:0];
    end
    return r;
  endfunction

  // stage f: normalized coordinates offset by one, y flipped
  always_ff @(posedge clk) begin
    if (f_rdy) begin
      f_nx   <= 34'(to_ndc(quo_x, div_side_out.neg_x)) + ONE;
      f_ny   <= ONE - 34'(to_ndc(quo_y, div_side_out.neg_y));
      f_side <= div_side_out;
    end
  end

  // stage g: scale by the viewport size
  always_ff @(posedge clk) begin
    if (g_rdy) begin
      g_px   <= f_nx * $signed({1'b0, vp_w});
      g_py   <= f_ny * $signed({1'b0, vp_h});
      g_side <= f_side;
    end
  end

  // stage h: viewport offset, saturation and special cases
  logic signed [65:0] sx_wide, sy_wide;
  always_comb begin
    sx_wide = $signed(66'(vp_x) << FRAC_BITS) + 66'(g_px >>> 1);
    sy_wide = $signed(66'(vp_y) << FRAC_BITS) + 66'(g_py >>> 1);
  end

  always_ff @(posedge clk) begin
    if (h_rdy) begin
      result.status <= g_side.status;
      result.clip_z <= g_side.clip_z;
      case (g_side.status)
        ST_BEHIND: begin
          result.screen_x <= '0;
          result.screen_y <= '0;
        end
        ST_W_ZERO: begin
          result.screen_x <= g_side.max_x ? S32_MAX : S32_MIN;
          result.screen_y <= g_side.max_y ? S32_MAX : S32_MIN;
        end
        default: begin
          result.screen_x <= sat32(sx_wide);
          result.screen_y <= sat32(sy_wide);
        end
      endcase
    end
  end

  assign result_valid = h_v;

endmodule

// ===== rtl/wsp_divider.sv =====
// pipelined restoring divider, two lanes with a shared divisor
// depends on wsp_pkg; quotient = (numerator << FRAC_BITS) / divisor, magnitudes
module wsp_divider #(
  parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF,
  localparam int QW = ((32 + FRAC_BITS + wsp_pkg::DIV_BITS - 1) / wsp_pkg::DIV_BITS)
                      * wsp_pkg::DIV_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         num_x,
  input  logic [31:0]         num_y,
  input  logic [31:0]         den,
  input  wsp_pkg::side_t      in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [QW-1:0]       quo_x,
  output logic [QW-1:0]       quo_y,
  output wsp_pkg::side_t      out_side
);
  import wsp_pkg::*;

  localparam int NS = QW / DIV_BITS;

  // DIV_BITS compare-subtract steps; remainder stays below a nonzero divisor
  function automatic logic [32+QW-1:0] div_step(input logic [31:0] r_in,
                                                input logic [QW-1:0] q_in,
                                                input logic [31:0] d);
    logic [31:0] r;
    logic [QW-1:0] q;
    logic [32:0] t;
    r = r_in;
    q = q_in;
    for (int j = 0; j < DIV_BITS; j++) begin
      t = {r, q[QW-1]};
      q = {q[QW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        q[0] = 1'b1;
      end
      r = t[31:0];
    end
    return {r, q};
  endfunction

  logic          v    [NS];
  logic          rdy  [NS+1];
  logic [31:0]   rx   [NS];
  logic [31:0]   ry   [NS];
  logic [QW-1:0] qx   [NS];
  logic [QW-1:0] qy   [NS];
  logic [31:0]   dv   [NS];
  side_t         sd   [NS];

  // stall chain: a stage takes new data when empty or when it drains
  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) rdy[k] = !v[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [31:0]   prx, pry, pd;
    logic [QW-1:0] pqx, pqy;
    logic          pv;
    side_t         ps;
    logic [32+QW-1:0] nx, ny;

    // previous stage or the entry point
    if (k == 0) begin : g_first
      assign pv  = in_valid;
      assign prx = '0;
      assign pry = '0;
      assign pqx = QW'(num_x) << FRAC_BITS;
      assign pqy = QW'(num_y) << FRAC_BITS;
      assign pd  = den;
      assign ps  = in_side;
    end else begin : g_next
      assign pv  = v[k-1];
      assign prx = rx[k-1];
      assign pry = ry[k-1];
      assign pqx = qx[k-1];
      assign pqy = qy[k-1];
      assign pd  = dv[k-1];
      assign ps  = sd[k-1];
    end

    assign nx = div_step(prx, pqx, pd);
    assign ny = div_step(pry, pqy, pd);

    // valid bit
    always_ff @(posedge clk) begin
      if (rst) v[k] <= 1'b0;
      else if (rdy[k]) v[k] <= pv;
    end

    // payload
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rx[k] <= nx[32+QW-1:QW];
        qx[k] <= nx[QW-1:0];
        ry[k] <= ny[32+QW-1:QW];
        qy[k] <= ny[QW-1:0];
        dv[k] <= pd;
        sd[k] <= ps;
      end
    end
  end

  assign out_valid = v[NS-1];
  assign quo_x     = qx[NS-1];
  assign quo_y     = qy[NS-1];
  assign out_side  = sd[NS-1];

endmodule

// ===== rtl/wsp_checker.sv =====
// port-level checks of the world to screen projection block, and their bind
// depends on wsp_pkg and world_to_screen_projection_assert.svh
module wsp_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input wsp_pkg::result_t result
);
  import wsp_pkg::*;
  `include "world_to_screen_projection_assert.svh"

  // a waiting result is not withdrawn
  `WSP_ASSERT_NEXT(a_result_held, clk, rst, result_valid && !result_ready, result_valid)

  // a point behind the camera reports all zero coordinates
  `WSP_ASSERT_NOW(a_behind_zero, clk, rst, result_valid && result.status == ST_BEHIND, result.screen_x == '0 && result.screen_y == '0 && result.clip_z == '0)

  // a zero clip w gives saturated screen coordinates
  `WSP_ASSERT_NOW(a_wzero_sat, clk, rst, result_valid && result.status == ST_W_ZERO, (result.screen_x == S32_MAX || result.screen_x == S32_MIN) && (result.screen_y == S32_MAX || result.screen_y == S32_MIN))

  // reset empties the output
  `WSP_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !result_valid)

endmodule

bind world_to_screen_projection wsp_checker u_wsp_checker (.*);

// ===== tb/tb_top.sv =====
// self-checking bench for world_to_screen_projection: random and directed items
// depends on wsp_pkg and the block's rtl; predicts each result in the bench
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wsp_pkg::*;

  localparam int FB = 16;
  localparam int ONE = 1 << FB;
  localparam int DRAIN = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vertex_valid = 1'b0;
  logic vertex_ready;
  vertex_t vertex = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  world_to_screen_projection dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] coefs [COEF_COUNT];
  longint vp_x, vp_y, vp_w, vp_h;

  vertex_t pending_items[$];
  result_t expected_results[$];
  int errors = 0;
  int gap_left = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint row(int base, longint a, longint b, longint c);
    longint acc;
    acc = ((longint'(coefs[base]) * a) >>> FB) + ((longint'(coefs[base+1]) * b) >>> FB)
        + ((longint'(coefs[base+2]) * c) >>> FB) + longint'(coefs[base+3]);
    return clamp32(acc);
  endfunction

  // apply one item to the predictor, queue the result it causes
  task automatic project_or_load(vertex_t v);
    longint ex, ey, ez, cx, cy, cz, cw, nx, ny, sx, sy;
    result_t r;
    if (v.op == OP_LOAD) begin
      if (v.coef_index < COEF_COUNT) coefs[v.coef_index] = v.coef_value;
      return;
    end
    ex = row(0, v.world_x, v.world_y, v.world_z);
    ey = row(4, v.world_x, v.world_y, v.world_z);
    ez = row(8, v.world_x, v.world_y, v.world_z);
    r = '0;
    if (ez > 0) begin
      r.status = ST_BEHIND;
    end else begin
      cx = row(PROJ_BASE, ex, ey, ez);
      cy = row(PROJ_BASE + 4, ex, ey, ez);
      cz = row(PROJ_BASE + 8, ex, ey, ez);
      cw = row(PROJ_BASE + 12, ex, ey, ez);
      r.clip_z = cz[31:0];
      if (cw == 0) begin
        r.status = ST_W_ZERO;
        r.screen_x = cx >= 0 ? S32_MAX : S32_MIN;
        r.screen_y = cy >= 0 ? S32_MAX : S32_MIN;
      end else begin
        nx = clamp32((cx * ONE) / cw);
        ny = clamp32((cy * ONE) / cw);
        sx = vp_x * ONE + (((nx + ONE) * vp_w) >>> 1);
        sy = vp_y * ONE + (((ONE - ny) * vp_h) >>> 1);
        r.status = ST_PROJECTED;
        r.screen_x = clamp32(sx);
        r.screen_y = clamp32(sy);
      end
    end
    expected_results.push_back(r);
  endtask

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // vertex driver
  always @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else if (!vertex_valid || vertex_ready) begin
      if (vertex_valid) project_or_load(vertex);
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        vertex_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        vertex <= pending_items.pop_front();
        vertex_valid <= 1'b1;
        gap_left <= rand_gap();
      end else begin
        vertex_valid <= 1'b0;
      end
    end
  end

  // result monitor with random stalls
  int stall_left = 0;
  always @(posedge clk) begin
    result_t e;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result %h", $time, result);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (result.status !== e.status || result.screen_x !== e.screen_x ||
              result.screen_y !== e.screen_y || result.clip_z !== e.clip_z) begin
            $display("%0t mismatch expected st=%0d x=%h y=%h z=%h actual st=%0d x=%h y=%h z=%h",
                     $time, e.status, e.screen_x, e.screen_y, e.clip_z,
                     result.status, result.screen_x, result.screen_y, result.clip_z);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        stall_left <= rand_gap();
      end
    end
  end

  function automatic vertex_t load_item(int idx, logic signed [31:0] val);
    vertex_t v;
    v = '0;
    v.op = OP_LOAD;
    v.coef_index = idx[4:0];
    v.coef_value = val;
    return v;
  endfunction

  function automatic vertex_t point_item(logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] z);
    vertex_t v;
    v.op = OP_PROJECT;
    v.coef_index = 5'($urandom());
    v.coef_value = $urandom();
    v.world_x = x;
    v.world_y = y;
    v.world_z = z;
    return v;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    if (p == 6) return ($urandom_range(0, 1) ? S32_MAX : S32_MIN);
    return $urandom();
  endfunction

  function automatic logic signed [31:0] rand_coef();
    int p;
    p = $urandom_range(0, 9);
    if (p < 7) return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
    if (p == 7) return 32'sd0;
    return $urandom();
  endfunction

  // typical camera: identity view, perspective with w = -ez
  task automatic load_camera();
    for (int i = 0; i < COEF_COUNT; i++) pending_items.push_back(load_item(i, 0));
    pending_items.push_back(load_item(0, ONE));
    pending_items.push_back(load_item(5, ONE));
    pending_items.push_back(load_item(10, ONE));
    pending_items.push_back(load_item(12, ONE));
    pending_items.push_back(load_item(17, ONE));
    pending_items.push_back(load_item(22, -ONE));
    pending_items.push_back(load_item(23, -2 * ONE));
    pending_items.push_back(load_item(26, -ONE));
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || vertex_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // caller drops cfg_valid after the last write
  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_VP_X: vp_x = val;
      CFG_VP_Y: vp_y = val;
      CFG_VP_WIDTH: vp_w = val;
      default: vp_h = val;
    endcase
  endtask

  initial begin
    logic [15:0] cfg_set [4][4];
    vertex_t v;
    vp_x = 0; vp_y = 0; vp_w = 640; vp_h = 480;
    foreach (coefs[i]) coefs[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: camera, extremes, behind camera, w zero, ignored index
    load_camera();
    pending_items.push_back(load_item(31, 32'sh1234_5678));
    pending_items.push_back(point_item(0, 0, -ONE));
    pending_items.push_back(point_item(ONE, -ONE, -4 * ONE));
    pending_items.push_back(point_item(0, 0, ONE));
    pending_items.push_back(point_item(S32_MAX, S32_MIN, S32_MIN));
    pending_items.push_back(point_item(S32_MIN, S32_MAX, S32_MIN));
    pending_items.push_back(point_item(-1, -1, -1));
    pending_items.push_back(point_item(5, 5, 0));
    pending_items.push_back(load_item(26, 0));
    pending_items.push_back(point_item(ONE, -ONE, -ONE));
    pending_items.push_back(point_item(0, 0, -ONE));
    pending_items.push_back(point_item(-ONE, ONE, -ONE));
    pending_items.push_back(load_item(27, 32'sh7FFF_FFFF));
    pending_items.push_back(point_item(S32_MAX, S32_MAX, S32_MIN));
    wait_idle();

    cfg_set = '{'{16'd0, 16'd0, 16'd1, 16'd1},
                '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                '{16'd100, 16'd50, 16'd0, 16'd0},
                '{16'h5A5A, 16'hA5A5, 16'd1920, 16'd1080}};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 4)
        for (int r = 0; r < 4; r++) write_reg(cfg_reg_t'(r), cfg_set[ph][r]);
      else
        for (int r = 0; r < 4; r++) write_reg(cfg_reg_t'(r), 16'($urandom()));
      cfg_valid <= 1'b0;
      load_camera();
      for (int n = 0; n < 300; n++) begin
        int p;
        p = $urandom_range(0, 99);
        if (p < 10) begin
          pending_items.push_back(load_item($urandom_range(0, 31), rand_coef()));
        end else if (p < 14) begin
          v = point_item(rand_coord(), rand_coord(), rand_coord());
          v.op = OP_LOAD;
          v.coef_index = 5'($urandom_range(12, 31));
          pending_items.push_back(v);
        end else begin
          pending_items.push_back(point_item(rand_coord(), rand_coord(), rand_coord()));
        end
      end
      wait_idle();
    end
    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: errors");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/wsp_pkg.sv
rtl/wsp_divider.sv
rtl/world_to_screen_projection.sv
rtl/wsp_checker.sv
tb/tb_top.sv
